>>> src/kti_pkg.sv
// Package: shared types and constants for the kinetic temperature block.
`default_nettype none

package kti_pkg;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int COORD_BITS    = 24;
    localparam int MASS_BITS     = 16;
    localparam int FACTOR_BITS   = 32;
    localparam int TEMP_BITS     = 32;
    localparam int SITE_BITS     = 24;
    localparam int SQ_BITS       = 48;
    localparam int V2_BITS       = 50;
    localparam int ENERGY_BITS   = 64;
    // Quotient numerator is factor * energy shifted right by 54 bits.
    localparam int NUM_BITS      = 42;
    localparam int NUM_SHIFT     = 22;
    localparam int DIV_CNT_BITS  = $clog2(NUM_BITS);

    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_LOW_X   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_LOW_Y   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_LOW_Z   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HIGH_X  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HIGH_Y  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HIGH_Z  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNIT_FACTOR = 3'd6;

    localparam logic signed [COORD_BITS-1:0] BOX_LOW_RESET  = 24'sd0;
    localparam logic signed [COORD_BITS-1:0] BOX_HIGH_RESET = 24'sd8388607;
    localparam logic [FACTOR_BITS-1:0]       FACTOR_RESET   = 32'd20177957;
    localparam logic [SITE_BITS-1:0]         SITE_MAX       = 24'hFFFFFF;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic signed [COORD_BITS-1:0] vel_x;
        logic signed [COORD_BITS-1:0] vel_y;
        logic signed [COORD_BITS-1:0] vel_z;
        logic [MASS_BITS-1:0]         particle_mass;
        logic                         last_particle;
    } t_particle;

    typedef struct packed {
        logic [TEMP_BITS-1:0] temperature;
        logic [SITE_BITS-1:0] site_count;
        logic                 region_empty;
    } t_result;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] low_x;
        logic signed [COORD_BITS-1:0] low_y;
        logic signed [COORD_BITS-1:0] low_z;
        logic signed [COORD_BITS-1:0] high_x;
        logic signed [COORD_BITS-1:0] high_y;
        logic signed [COORD_BITS-1:0] high_z;
    } t_box;

    // Classified particle as held in the queue between front and back.
    typedef struct packed {
        logic                         in_box;
        logic signed [COORD_BITS-1:0] vel_x;
        logic signed [COORD_BITS-1:0] vel_y;
        logic signed [COORD_BITS-1:0] vel_z;
        logic [MASS_BITS-1:0]         mass;
        logic                         last;
    } t_task;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

>>> src/kti_front.sv
// Front end: classifies each incoming particle against the measurement box.
`default_nettype none

module kti_front
    import kti_pkg::*;
(
    input  wire t_particle i_item,
    input  wire t_box      i_box,
    output t_task          o_task
);

    logic in_x;
    logic in_y;
    logic in_z;

    // Low bound inclusive, high bound exclusive; an inverted box holds nothing.
    assign in_x = (i_item.pos_x >= i_box.low_x) && (i_item.pos_x < i_box.high_x);
    assign in_y = (i_item.pos_y >= i_box.low_y) && (i_item.pos_y < i_box.high_y);
    assign in_z = (i_item.pos_z >= i_box.low_z) && (i_item.pos_z < i_box.high_z);

    always_comb begin
        o_task.in_box = in_x && in_y && in_z;
        o_task.vel_x  = i_item.vel_x;
        o_task.vel_y  = i_item.vel_y;
        o_task.vel_z  = i_item.vel_z;
        o_task.mass   = i_item.particle_mass;
        o_task.last   = i_item.last_particle;
    end

endmodule

`default_nettype wire

>>> src/kti_queue.sv
// Short queue of classified particles between front end and back end.
`default_nettype none

module kti_queue
    import kti_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_wr,
    input  wire t_task i_data,
    input  wire        i_rd,
    output t_task      o_head,
    output t_qstat     o_stat
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR  = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(DEPTH);

    t_task               r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                do_wr;
    logic                do_rd;

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign do_wr        = i_wr && !o_stat.full;
    assign do_rd        = i_rd && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/kti_back.sv
// Back end: energy accumulation, site counting and the final temperature divide.
`default_nettype none

module kti_back
    import kti_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire t_task             i_head,
    input  wire t_qstat            i_q_stat,
    output logic                   o_q_pop,
    input  wire [FACTOR_BITS-1:0]  i_factor,
    output t_result                o_result,
    output logic                   o_res_valid,
    input  wire                    i_pop
);

    localparam int DIV_BITS = COUNT_BITS + 2;
    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(NUM_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TERM,
        S_ACC,
        S_PLO,
        S_PHI,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [V2_BITS-1:0]      r_v2;
    logic [MASS_BITS-1:0]    r_mass;
    logic                    r_inside;
    logic                    r_last;
    logic [ENERGY_BITS-1:0]  r_term;
    logic [ENERGY_BITS-1:0]  r_acc;
    logic [COUNT_BITS-1:0]   r_count;
    logic [2*FACTOR_BITS-1:0] r_plo;
    logic [2*FACTOR_BITS-1:0] r_phi;
    logic [NUM_BITS-1:0]     r_num;
    logic [NUM_BITS-1:0]     r_quo;
    logic [DIV_BITS-1:0]     r_rem;
    logic [DIV_BITS-1:0]     r_div;
    logic [DIV_CNT_BITS-1:0] r_step;
    t_result                 r_res;
    logic                    r_res_valid;

    logic signed [SQ_BITS-1:0]     sq_x;
    logic signed [SQ_BITS-1:0]     sq_y;
    logic signed [SQ_BITS-1:0]     sq_z;
    logic [V2_BITS-1:0]            v2;
    logic [V2_BITS+MASS_BITS-1:0]  term_full;
    logic [ENERGY_BITS:0]          acc_sum;
    logic [2*FACTOR_BITS-1:0]      prod;
    logic [2*FACTOR_BITS:0]        hi_sum;
    logic [DIV_BITS:0]             rem_sh;
    logic                          rem_ge;
    logic [DIV_BITS:0]             rem_diff;
    logic [31:0]                   count_ext;
    logic [SITE_BITS-1:0]          site;
    logic                          res_free;
    logic                          res_load;

    assign sq_x = i_head.vel_x * i_head.vel_x;
    assign sq_y = i_head.vel_y * i_head.vel_y;
    assign sq_z = i_head.vel_z * i_head.vel_z;
    assign v2   = V2_BITS'($unsigned(sq_x)) + V2_BITS'($unsigned(sq_y))
                + V2_BITS'($unsigned(sq_z));

    // The scaled term stays below 2^64, so the top product bits are always zero.
    assign term_full = r_v2 * r_mass;
    assign acc_sum   = {1'b0, r_acc} + {1'b0, r_term};

    // One shared 32 by 32 multiplier serves both halves of the energy sum.
    assign prod   = i_factor * ((r_state == S_PLO) ? r_acc[31:0] : r_acc[63:32]);
    assign hi_sum = {1'b0, r_phi} + (2*FACTOR_BITS+1)'(r_plo[63:32]);

    assign rem_sh   = {r_rem, r_num[NUM_BITS-1]};
    assign rem_diff = rem_sh - {1'b0, r_div};
    assign rem_ge   = (rem_sh >= {1'b0, r_div});

    assign count_ext = 32'(r_count);
    assign site      = (count_ext > 32'(SITE_MAX)) ? SITE_MAX : count_ext[SITE_BITS-1:0];

    assign res_free    = !r_res_valid || i_pop;
    assign res_load    = (r_state == S_EMIT) && res_free;
    assign o_q_pop     = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_result    = r_res;
    assign o_res_valid = r_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_v2     <= v2;
                        r_mass   <= i_head.mass;
                        r_inside <= i_head.in_box;
                        r_last   <= i_head.last;
                        r_state  <= S_TERM;
                    end
                end
                S_TERM: begin
                    r_term  <= term_full[ENERGY_BITS-1:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_inside) begin
                        r_acc <= acc_sum[ENERGY_BITS] ? '1 : acc_sum[ENERGY_BITS-1:0];
                        if (r_count != '1) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    r_state <= r_last ? S_PLO : S_IDLE;
                end
                S_PLO: begin
                    r_plo   <= prod;
                    r_state <= S_PHI;
                end
                S_PHI: begin
                    r_phi   <= prod;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_num   <= hi_sum[NUM_SHIFT +: NUM_BITS];
                    r_div   <= {2'b00, r_count} + {1'b0, r_count, 1'b0};
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    r_rem  <= rem_ge ? rem_diff[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
                    r_quo  <= {r_quo[NUM_BITS-2:0], rem_ge};
                    r_num  <= {r_num[NUM_BITS-2:0], 1'b0};
                    r_step <= r_step + 1'b1;
                    if (r_step == DIV_LAST) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (res_free) begin
                        if (r_count == '0) begin
                            r_res.temperature  <= '0;
                            r_res.site_count   <= '0;
                            r_res.region_empty <= 1'b1;
                        end else begin
                            r_res.temperature  <= (r_quo[NUM_BITS-1:TEMP_BITS] != '0) ?
                                                  '1 : r_quo[TEMP_BITS-1:0];
                            r_res.site_count   <= site;
                            r_res.region_empty <= 1'b0;
                        end
                        r_acc       <= '0;
                        r_count     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/kinetic_temperature_in_box_top.sv
// Top level: kinetic temperature of the particles inside a configured box.
//
//  Channel   Handshake          Payload     Direction
//  particle  push / full        i_item      in
//  result    pop / empty        o_result    out
//  config    i_cfg_we           i_cfg_idx, i_cfg_data  in
//
// The back end takes each particle through squares, mass scaling and accumulation,
// and only then takes the next word, which sets the input rate once the queue is full.
// A word marked last is followed by the two multiplier passes and the
// 42-step restoring divider, plus any wait for the previous result to be popped.
// The front end classifies a word in its accepting cycle and parks it in a
// queue of QUEUE_DEPTH entries; full rises when that queue holds QUEUE_DEPTH.
// Reset is synchronous and clears the accumulator, counter, queue and result valid flag.
`default_nettype none

module kinetic_temperature_in_box_top
    import kti_pkg::*;
#(
    parameter int COUNT_BITS  = 24,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      push,
    output logic                     full,
    input  wire t_particle           i_item,
    output logic                     empty,
    input  wire                      pop,
    output t_result                  o_result,
    input  wire                      i_cfg_we,
    input  wire [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_box                   r_box;
    logic [FACTOR_BITS-1:0] r_factor;
    t_task                  front_task;
    t_task                  q_head;
    t_qstat                 q_stat;
    logic                   q_pop;
    logic                   res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.low_x  <= BOX_LOW_RESET;
            r_box.low_y  <= BOX_LOW_RESET;
            r_box.low_z  <= BOX_LOW_RESET;
            r_box.high_x <= BOX_HIGH_RESET;
            r_box.high_y <= BOX_HIGH_RESET;
            r_box.high_z <= BOX_HIGH_RESET;
            r_factor     <= FACTOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BOX_LOW_X:   r_box.low_x  <= i_cfg_data[COORD_BITS-1:0];
                REG_BOX_LOW_Y:   r_box.low_y  <= i_cfg_data[COORD_BITS-1:0];
                REG_BOX_LOW_Z:   r_box.low_z  <= i_cfg_data[COORD_BITS-1:0];
                REG_BOX_HIGH_X:  r_box.high_x <= i_cfg_data[COORD_BITS-1:0];
                REG_BOX_HIGH_Y:  r_box.high_y <= i_cfg_data[COORD_BITS-1:0];
                REG_BOX_HIGH_Z:  r_box.high_z <= i_cfg_data[COORD_BITS-1:0];
                REG_UNIT_FACTOR: r_factor     <= i_cfg_data[FACTOR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    kti_front u_front (
        .i_item (i_item),
        .i_box  (r_box),
        .o_task (front_task)
    );

    kti_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (front_task),
        .i_rd    (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    kti_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_q_stat    (q_stat),
        .o_q_pop     (q_pop),
        .i_factor    (r_factor),
        .o_result    (o_result),
        .o_res_valid (res_valid),
        .i_pop       (pop)
    );

    assign full  = q_stat.full;
    assign empty = !res_valid;

`ifndef NO_ASSERTIONS
    // An empty region is flagged exactly when no site was counted.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.region_empty == (o_result.site_count == '0)))
        else $error("region_empty disagrees with site_count");

    a_empty_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.region_empty) |-> (o_result.temperature == '0))
        else $error("empty region reported a non-zero temperature");

    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_pop_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("back end took a word from an empty queue");
`endif

endmodule

`default_nettype wire
